@@ src/xcr_pkg.sv @@
// ---------------------------------------------------------------------------
// xcr_pkg: shared definitions for the xmodem checksum receiver
// Protocol characters, frame geometry, result codes and the job format that
// travels from the front end through the queue to the back end.
// ---------------------------------------------------------------------------
package xcr_pkg;

  // frame geometry
  localparam int BLOCK_BYTES = 128;
  localparam int FRAME_BYTES = BLOCK_BYTES + 4;
  localparam int FC_W        = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W      = 32;

  // protocol characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  // input operations
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_RESP  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // end status codes
  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_EOT      = 3'd1;
  localparam logic [2:0] ST_CANCEL   = 3'd2;
  localparam logic [2:0] ST_SUM_ERR  = 3'd3;
  localparam logic [2:0] ST_SEQ_ERR  = 3'd4;

  // job format: up to four results per input item
  localparam int MAX_RES = 4;
  localparam int SLOT_W  = $clog2(MAX_RES);
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] status;
  } slot_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] addr;
    slot_t [MAX_RES-1:0] slot;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ src/xcr_in_if.sv @@
// ---------------------------------------------------------------------------
// xcr_in_if: input channel of the xmodem receiver
// One beat carries a received byte or a receive timeout.
// ---------------------------------------------------------------------------
interface xcr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

@@ src/xcr_out_if.sv @@
// ---------------------------------------------------------------------------
// xcr_out_if: result channel of the xmodem receiver
// One beat carries a response byte, a memory write or the end of transfer.
// ---------------------------------------------------------------------------
interface xcr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [31:0] write_address;
  logic [2:0]  end_status;
  logic        last;

  modport source (output valid, output kind, output byte_value, output write_address,
                  output end_status, output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input write_address,
                  input end_status, input last, output ready);
endinterface

@@ src/xcr_front.sv @@
// ---------------------------------------------------------------------------
// xcr_front: frame tracking and classification
// Accepts one beat per cycle while the queue is not full, keeps the frame
// and transfer state, and turns each beat into a job listing its results.
// ---------------------------------------------------------------------------
module xcr_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [31:0]              cfg_wdata,
  xcr_in_if.sink                   in_ch,
  input  xcr_pkg::q_stat_t         q_stat,
  output logic                     push,
  output xcr_pkg::job_t            job
);

  logic [31:0]              base_address;
  logic [xcr_pkg::FC_W-1:0] frame_count, frame_count_next;
  logic [7:0]               first_byte, first_byte_next;
  logic [7:0]               frame_seq_byte, frame_seq_byte_next;
  logic [7:0]               running_sum, running_sum_next;
  logic [7:0]               expected_seq, expected_seq_next;
  logic [31:0]              write_offset, write_offset_next;
  logic                     block_seen, block_seen_next;
  logic                     finished, finished_next;

  logic                     accept;
  logic [xcr_pkg::FC_W-1:0] pos_inc;
  logic [7:0]               seq_inc;
  logic [xcr_pkg::CNT_W-1:0] n;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pos_inc     = frame_count + xcr_pkg::FC_W'(1);
  assign seq_inc     = expected_seq + 8'd1;

  // next state and job contents
  always_comb begin
    frame_count_next    = frame_count;
    first_byte_next     = first_byte;
    frame_seq_byte_next = frame_seq_byte;
    running_sum_next    = running_sum;
    expected_seq_next   = expected_seq;
    write_offset_next   = write_offset;
    block_seen_next     = block_seen;
    finished_next       = finished;
    job                 = '0;
    n                   = '0;
    if (!finished) begin
      if (in_ch.operation == xcr_pkg::OP_BYTE) begin
        // header, data or checksum byte
        if (frame_count == '0) begin
          first_byte_next = in_ch.rx_byte;
        end else if (frame_count == xcr_pkg::FC_W'(1)) begin
          frame_seq_byte_next = in_ch.rx_byte;
        end else if (frame_count >= xcr_pkg::FC_W'(3) &&
                     frame_count < xcr_pkg::FC_W'(xcr_pkg::FRAME_BYTES - 1)) begin
          running_sum_next = running_sum + in_ch.rx_byte;
          job.addr = base_address + write_offset +
                     32'(frame_count - xcr_pkg::FC_W'(3));
          job.slot[n[xcr_pkg::SLOT_W-1:0]] =
            '{xcr_pkg::KIND_WRITE, in_ch.rx_byte, xcr_pkg::ST_RUN};
          n = n + xcr_pkg::CNT_W'(1);
        end
        frame_count_next = pos_inc;
        // frame complete
        if (pos_inc == xcr_pkg::FC_W'(xcr_pkg::FRAME_BYTES)) begin
          if (!block_seen) begin
            block_seen_next = 1'b1;
            job.slot[n[xcr_pkg::SLOT_W-1:0]] =
              '{xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, xcr_pkg::ST_RUN};
            n = n + xcr_pkg::CNT_W'(1);
            job.slot[n[xcr_pkg::SLOT_W-1:0]] =
              '{xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, xcr_pkg::ST_RUN};
            n = n + xcr_pkg::CNT_W'(1);
          end
          job.slot[n[xcr_pkg::SLOT_W-1:0]] =
            '{xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, xcr_pkg::ST_RUN};
          n = n + xcr_pkg::CNT_W'(1);
          if (first_byte == xcr_pkg::CH_SOH) begin
            if (running_sum != in_ch.rx_byte) begin
              job.slot[n[xcr_pkg::SLOT_W-1:0]] =
                '{xcr_pkg::KIND_DONE, xcr_pkg::CH_CAN, xcr_pkg::ST_SUM_ERR};
              n = n + xcr_pkg::CNT_W'(1);
              finished_next = 1'b1;
            end else if (seq_inc != frame_seq_byte) begin
              job.slot[n[xcr_pkg::SLOT_W-1:0]] =
                '{xcr_pkg::KIND_DONE, xcr_pkg::CH_CAN, xcr_pkg::ST_SEQ_ERR};
              n = n + xcr_pkg::CNT_W'(1);
              finished_next = 1'b1;
            end else begin
              expected_seq_next = seq_inc;
              write_offset_next = write_offset + 32'(xcr_pkg::BLOCK_BYTES);
            end
          end
          frame_count_next    = '0;
          first_byte_next     = '0;
          frame_seq_byte_next = '0;
          running_sum_next    = '0;
        end
      end else begin
        // receive timeout closes the frame
        if (frame_count == '0) begin
          if (!block_seen) begin
            job.slot[0] = '{xcr_pkg::KIND_RESP, xcr_pkg::CH_NAK, xcr_pkg::ST_RUN};
            n = xcr_pkg::CNT_W'(1);
          end else begin
            job.slot[0] = '{xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, xcr_pkg::ST_RUN};
            job.slot[1] = '{xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, xcr_pkg::ST_RUN};
            n = xcr_pkg::CNT_W'(2);
          end
        end else if (first_byte == xcr_pkg::CH_EOT) begin
          job.slot[0] = '{xcr_pkg::KIND_DONE, xcr_pkg::CH_ACK, xcr_pkg::ST_EOT};
          n = xcr_pkg::CNT_W'(1);
          finished_next = 1'b1;
        end else if (first_byte == xcr_pkg::CH_CAN) begin
          job.slot[0] = '{xcr_pkg::KIND_DONE, xcr_pkg::CH_ACK, xcr_pkg::ST_CANCEL};
          n = xcr_pkg::CNT_W'(1);
          finished_next = 1'b1;
        end else begin
          job.slot[0] = '{xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, xcr_pkg::ST_RUN};
          n = xcr_pkg::CNT_W'(1);
        end
        frame_count_next    = '0;
        first_byte_next     = '0;
        frame_seq_byte_next = '0;
        running_sum_next    = '0;
      end
    end
    job.count = n;
  end

  // only beats with results go to the queue
  assign push = accept && (n != '0);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= '0;
      frame_count    <= '0;
      first_byte     <= '0;
      frame_seq_byte <= '0;
      running_sum    <= '0;
      expected_seq   <= '0;
      write_offset   <= '0;
      block_seen     <= 1'b0;
      finished       <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_address <= cfg_wdata;
      end
      if (accept) begin
        frame_count    <= frame_count_next;
        first_byte     <= first_byte_next;
        frame_seq_byte <= frame_seq_byte_next;
        running_sum    <= running_sum_next;
        expected_seq   <= expected_seq_next;
        write_offset   <= write_offset_next;
        block_seen     <= block_seen_next;
        finished       <= finished_next;
      end
    end
  end

`ifndef SYNTHESIS
  // once ended, the transfer stays ended
  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("transfer restarted after end");

  // the frame counter never passes a full frame
  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count < xcr_pkg::FC_W'(xcr_pkg::FRAME_BYTES))
    else $error("frame counter out of range");
`endif

endmodule

@@ src/xcr_queue.sv @@
// ---------------------------------------------------------------------------
// xcr_queue: job queue between front and back
// Small first-in first-out buffer of jobs so both sides stall on their own.
// ---------------------------------------------------------------------------
module xcr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xcr_pkg::job_t     push_job,
  input  logic              pop,
  output xcr_pkg::job_t     head,
  output xcr_pkg::q_stat_t  q_stat
);

  xcr_pkg::job_t               entries [xcr_pkg::QUEUE_DEPTH];
  logic [xcr_pkg::QPTR_W-1:0]  wr_ptr;
  logic [xcr_pkg::QPTR_W-1:0]  rd_ptr;
  logic [xcr_pkg::QCNT_W-1:0]  count;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = (count == xcr_pkg::QCNT_W'(xcr_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + xcr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + xcr_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + xcr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - xcr_pkg::QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // no push into a full queue, no pop from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job popped from empty queue");
`endif

endmodule

@@ src/xcr_back.sv @@
// ---------------------------------------------------------------------------
// xcr_back: result sequencer
// Walks the slots of the job at the queue head into the output register,
// one result beat per cycle while out_ch.ready lets the register drain.
// ---------------------------------------------------------------------------
module xcr_back (
  input  logic              clk,
  input  logic              rst,
  input  xcr_pkg::job_t     head,
  input  xcr_pkg::q_stat_t  q_stat,
  output logic              pop,
  xcr_out_if.source         out_ch
);

  logic [xcr_pkg::SLOT_W-1:0] idx;
  logic                       take;
  logic                       slot_last;
  xcr_pkg::slot_t             cur;

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_value;
  logic [31:0] out_addr;
  logic [2:0]  out_status;
  logic        out_last;

  assign cur       = head.slot[idx];
  assign slot_last = ({1'b0, idx} == head.count - xcr_pkg::CNT_W'(1));
  assign take      = !q_stat.empty && (!out_valid || out_ch.ready);
  assign pop       = take && slot_last;

  // slot walk within a job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      if (slot_last) begin
        idx <= '0;
      end else begin
        idx <= idx + xcr_pkg::SLOT_W'(1);
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_kind   <= cur.kind;
      out_value  <= cur.value;
      out_addr   <= (cur.kind == xcr_pkg::KIND_WRITE) ? head.addr : '0;
      out_status <= cur.status;
      out_last   <= slot_last;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.kind          = out_kind;
  assign out_ch.byte_value    = out_value;
  assign out_ch.write_address = out_addr;
  assign out_ch.end_status    = out_status;
  assign out_ch.last          = out_last;

`ifndef SYNTHESIS
  // the end of transfer is always the final result of its beat
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == xcr_pkg::KIND_DONE) |-> out_last)
    else $error("end of transfer not marked last");

  // only writes carry an address
  a_addr_only_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != xcr_pkg::KIND_WRITE) |-> (out_addr == '0))
    else $error("address on a non-write result");
`endif

endmodule

@@ src/xmodem_checksum_receiver.sv @@
// ---------------------------------------------------------------------------
// xmodem_checksum_receiver: XMODEM receiver, 128-byte blocks, 8-bit checksum
// Usage:
//   in_ch  carries one beat per received byte or receive timeout.
//   out_ch carries result beats: response bytes, data writes at
//          base_address plus offset, and the end-of-transfer mark; last
//          flags the final result of each input beat.
//   cfg_we / cfg_wdata write base_address while the block is idle.
// Path: a beat's results pass through the job queue and the output register.
// Throughput: one input beat per cycle while the queue is not full; the
//   back end sends one result per cycle while out_ch.ready allows, so a
//   beat with several results holds the result side longer; a four-entry
//   job queue absorbs the difference.
// Beats with no results (header bytes, anything after the end) push nothing.
// Reset: synchronous; clears all frame and transfer state and the queue.
// Stall: when out_ch.ready is low the queue fills and then in_ch.ready
//   drops; nothing is lost.
// ---------------------------------------------------------------------------
module xmodem_checksum_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  xcr_in_if.sink      in_ch,
  xcr_out_if.source   out_ch
);

  logic              push;
  logic              pop;
  xcr_pkg::job_t     push_job;
  xcr_pkg::job_t     head;
  xcr_pkg::q_stat_t  q_stat;

  // frame tracking and classification
  xcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  // job queue
  xcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // result sequencing
  xcr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ tb/xmodem_checksum_receiver_checker.sv @@
// ---------------------------------------------------------------------------
// xmodem_checksum_receiver_checker: result checker for the xmodem receiver
// Watches the input and result channels and the base address port, keeps
// its own copy of the receiver's frame and transfer state, works out the
// actions each accepted beat should cause and compares every result beat
// field by field against the oldest one still due.
// ---------------------------------------------------------------------------
module xmodem_checksum_receiver_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  xcr_in_if           in_ch,
  xcr_out_if          out_ch,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [31:0] addr;
    logic [2:0]  status;
    logic        last;
  } rx_action_t;

  // mirrored receiver state
  logic [31:0] base_address;
  int          frame_count;
  logic [7:0]  lead_byte;
  logic [7:0]  seq_byte;
  logic [7:0]  data_sum;
  logic [7:0]  block_seq;
  logic [31:0] data_offset;
  logic        block_seen;
  logic        done;

  rx_action_t  due_actions[$];
  rx_action_t  batch[xcr_pkg::MAX_RES];
  rx_action_t  head;
  int          batch_len;
  int          fail_total = 0;

  task automatic add_action(input logic [1:0] kind, input logic [7:0] value,
                            input logic [31:0] addr, input logic [2:0] status);
    batch[batch_len] = '{kind, value, addr, status, 1'b0};
    batch_len++;
  endtask

  task automatic clear_frame();
    frame_count = 0;
    lead_byte   = '0;
    seq_byte    = '0;
    data_sum    = '0;
  endtask

  // actions caused by one accepted input beat
  task automatic receive_item(input logic op, input logic [7:0] b);
    logic [7:0]  next_seq;
    logic [31:0] data_index;
    int          i;
    batch_len = 0;
    if (!done) begin
      if (op == xcr_pkg::OP_BYTE) begin
        // lead and sequence bytes are only stored, data bytes are written at once
        if (frame_count == 0) begin
          lead_byte = b;
        end else if (frame_count == 1) begin
          seq_byte = b;
        end else if (frame_count >= 3 && frame_count < xcr_pkg::FRAME_BYTES - 1) begin
          data_index = 32'(frame_count - 3);
          data_sum   = data_sum + b;
          add_action(xcr_pkg::KIND_WRITE, b,
                     base_address + data_offset + data_index, xcr_pkg::ST_RUN);
        end
        frame_count++;
        // complete frame: acknowledge, then verify when led by SOH
        if (frame_count >= xcr_pkg::FRAME_BYTES) begin
          if (!block_seen) begin
            block_seen = 1'b1;
            add_action(xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, '0, xcr_pkg::ST_RUN);
            add_action(xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, '0, xcr_pkg::ST_RUN);
          end
          add_action(xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, '0, xcr_pkg::ST_RUN);
          if (lead_byte == xcr_pkg::CH_SOH) begin
            next_seq = block_seq + 8'd1;
            if (data_sum != b) begin
              add_action(xcr_pkg::KIND_DONE, xcr_pkg::CH_CAN, '0, xcr_pkg::ST_SUM_ERR);
              done = 1'b1;
            end else if (next_seq != seq_byte) begin
              add_action(xcr_pkg::KIND_DONE, xcr_pkg::CH_CAN, '0, xcr_pkg::ST_SEQ_ERR);
              done = 1'b1;
            end else begin
              block_seq   = next_seq;
              data_offset = data_offset + 32'(xcr_pkg::BLOCK_BYTES);
            end
          end
          clear_frame();
        end
      end else begin
        // receive timeout closes whatever was gathered
        if (frame_count == 0) begin
          if (!block_seen) begin
            add_action(xcr_pkg::KIND_RESP, xcr_pkg::CH_NAK, '0, xcr_pkg::ST_RUN);
          end else begin
            add_action(xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, '0, xcr_pkg::ST_RUN);
            add_action(xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, '0, xcr_pkg::ST_RUN);
          end
        end else if (lead_byte == xcr_pkg::CH_EOT) begin
          add_action(xcr_pkg::KIND_DONE, xcr_pkg::CH_ACK, '0, xcr_pkg::ST_EOT);
          done = 1'b1;
        end else if (lead_byte == xcr_pkg::CH_CAN) begin
          add_action(xcr_pkg::KIND_DONE, xcr_pkg::CH_ACK, '0, xcr_pkg::ST_CANCEL);
          done = 1'b1;
        end else begin
          add_action(xcr_pkg::KIND_RESP, xcr_pkg::CH_ACK, '0, xcr_pkg::ST_RUN);
        end
        clear_frame();
      end
    end
    for (i = 0; i < batch_len; i++) begin
      if (i == batch_len - 1) begin
        batch[i].last = 1'b1;
      end
      due_actions.push_back(batch[i]);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_total++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // track config, predict on input beats, check result beats
  always @(posedge clk) begin
    if (rst) begin
      base_address = '0;
      clear_frame();
      block_seq   = '0;
      data_offset = '0;
      block_seen  = 1'b0;
      done        = 1'b0;
      due_actions.delete();
    end else begin
      if (cfg_we) begin
        base_address = cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        receive_item(in_ch.operation, in_ch.rx_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_actions.size() == 0) begin
          fail_total++;
          $display("%0t: extra result, expected none, actual %0d/%0h/%0h/%0d",
                   $time, out_ch.kind, out_ch.byte_value, out_ch.write_address,
                   out_ch.end_status);
        end else begin
          head = due_actions.pop_front();
          compare_field("kind", 32'(head.kind), 32'(out_ch.kind));
          compare_field("byte_value", 32'(head.value), 32'(out_ch.byte_value));
          compare_field("write_address", head.addr, out_ch.write_address);
          compare_field("end_status", 32'(head.status), 32'(out_ch.end_status));
          compare_field("last", 32'(head.last), 32'(out_ch.last));
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= due_actions.size();
  end

endmodule

@@ tb/xmodem_checksum_receiver_tb.sv @@
// ---------------------------------------------------------------------------
// xmodem_checksum_receiver_tb: top level test of the xmodem receiver
// Drives a short directed opening, one complete block under a long result
// hold-off, then phases of partial frames and timeouts under changing sender
// and receiver idling and base addresses, then one randomly chosen way of
// ending the transfer and a few beats that must be ignored. The checker
// beside the block does all predicting and comparing.
// ---------------------------------------------------------------------------
module xmodem_checksum_receiver_tb;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_BEATS   = 40;
  localparam int IGNORED_BEATS = 8;

  typedef enum int {END_EOT, END_CANCEL, END_SUM, END_SEQ} ending_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          mismatches;
  int          outstanding;
  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          beats_sent = 0;
  int          quiet_cycles = 0;
  logic [7:0]  next_seq = 8'd1;

  xcr_in_if  in_ch();
  xcr_out_if out_ch();

  xmodem_checksum_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  xmodem_checksum_receiver_checker rx_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side ready, with one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("xmodem_checksum_receiver_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one beat, with a random gap first, until it is taken
  task automatic send_beat(input logic op, input logic [7:0] b);
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.rx_byte   <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_timeout();
    logic [7:0] noise;
    noise = 8'($urandom_range(255));
    send_beat(xcr_pkg::OP_TIMEOUT, noise);
  endtask

  // full frame of header, random or constant data, and checksum
  task automatic send_frame(input logic [7:0] lead, input logic [7:0] seq, input bit bad_sum);
    logic [7:0] data [xcr_pkg::BLOCK_BYTES];
    logic [7:0] sum;
    logic [7:0] seq_inv;
    logic [7:0] skew;
    int         style;
    int         i;
    style = $urandom_range(7);
    sum   = '0;
    for (i = 0; i < xcr_pkg::BLOCK_BYTES; i++) begin
      data[i] = 8'($urandom_range(255));
      if (style == 0) data[i] = 8'h00;
      if (style == 1) data[i] = 8'hFF;
      sum = sum + data[i];
    end
    if (bad_sum) begin
      skew = 8'($urandom_range(1, 255));
      sum  = sum + skew;
    end
    seq_inv = ~seq;
    if ($urandom_range(3) == 0) seq_inv = 8'($urandom_range(255));
    send_beat(xcr_pkg::OP_BYTE, lead);
    send_beat(xcr_pkg::OP_BYTE, seq);
    send_beat(xcr_pkg::OP_BYTE, seq_inv);
    for (i = 0; i < xcr_pkg::BLOCK_BYTES; i++) send_beat(xcr_pkg::OP_BYTE, data[i]);
    send_beat(xcr_pkg::OP_BYTE, sum);
  endtask

  // frame cut short by a timeout after len bytes
  task automatic send_partial(input logic [7:0] lead, input int len);
    logic [7:0] b;
    int         i;
    send_beat(xcr_pkg::OP_BYTE, lead);
    for (i = 1; i < len; i++) begin
      b = 8'($urandom_range(255));
      send_beat(xcr_pkg::OP_BYTE, b);
    end
    send_timeout();
  endtask

  // stop offering and wait until every due result has come
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    settle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    ending_t    ending;
    int         phase;
    int         start;
    int         pick;
    int         len;
    int         i;
    logic [7:0] lead;
    logic [7:0] seq;
    logic [7:0] b;

    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= xcr_pkg::OP_BYTE;
    in_ch.rx_byte   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: NAK before any block, partial frames, address wrap
    write_base(32'hFFFF_FFF8);
    send_timeout();
    send_timeout();
    send_beat(xcr_pkg::OP_BYTE, xcr_pkg::CH_SOH);
    send_beat(xcr_pkg::OP_BYTE, 8'h00);
    send_beat(xcr_pkg::OP_BYTE, 8'hFF);
    send_beat(xcr_pkg::OP_BYTE, 8'h00);
    send_beat(xcr_pkg::OP_BYTE, 8'hFF);
    send_beat(xcr_pkg::OP_BYTE, 8'h80);
    send_beat(xcr_pkg::OP_BYTE, 8'h7F);
    send_beat(xcr_pkg::OP_BYTE, 8'h01);
    send_beat(xcr_pkg::OP_BYTE, 8'h55);
    send_beat(xcr_pkg::OP_BYTE, 8'hAA);
    send_beat(xcr_pkg::OP_BYTE, 8'h12);
    send_beat(xcr_pkg::OP_BYTE, 8'hFE);
    send_beat(xcr_pkg::OP_BYTE, 8'h33);
    send_timeout();
    send_beat(xcr_pkg::OP_BYTE, 8'hFF);
    send_beat(xcr_pkg::OP_BYTE, 8'h00);
    send_timeout();
    send_timeout();

    // random phases with their own idling and base address
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_base(32'h0000_0000);
          gap_pct = 0;  stall_pct = 0;
        end
        1: begin
          write_base(32'hFFFF_FFFF);
          gap_pct = 88; stall_pct = 0;
        end
        2: begin
          write_base($urandom());
          gap_pct = 0;  stall_pct = 88;
        end
        default: begin
          write_base($urandom());
          gap_pct = 27; stall_pct = 27;
        end
      endcase
      start = beats_sent;
      if (phase == 0) begin
        // long result hold-off while a block streams in
        hold_req = 1'b1;
        send_frame(xcr_pkg::CH_SOH, next_seq, 1'b0);
        next_seq++;
      end
      while (beats_sent - start < PHASE_BEATS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          do lead = 8'($urandom_range(255));
          while (lead == xcr_pkg::CH_EOT || lead == xcr_pkg::CH_CAN);
          len = ($urandom_range(5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          send_partial(lead, len);
        end else begin
          send_timeout();
        end
      end
    end

    // end the transfer one way or another
    ending = ending_t'($urandom_range(3));
    case (ending)
      END_EOT:    send_partial(xcr_pkg::CH_EOT, $urandom_range(1, 4));
      END_CANCEL: send_partial(xcr_pkg::CH_CAN, $urandom_range(1, 4));
      END_SUM:    send_frame(xcr_pkg::CH_SOH, next_seq, 1'b1);
      default: begin
        seq = next_seq + 8'($urandom_range(1, 255));
        send_frame(xcr_pkg::CH_SOH, seq, 1'b0);
      end
    endcase

    // beats after the end must cause nothing
    for (i = 0; i < IGNORED_BEATS; i++) begin
      if ($urandom_range(1) == 0) begin
        send_timeout();
      end else begin
        b = 8'($urandom_range(255));
        send_beat(xcr_pkg::OP_BYTE, b);
      end
    end

    stall_pct = 0;
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("xmodem_checksum_receiver_tb OK");
    end else begin
      $display("xmodem_checksum_receiver_tb NOT OK");
    end
    $finish;
  end

endmodule
